>>> rtl/ppt_pkg.sv
package ppt_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 32;

	// Quaternion parts are Q2.14, yaw cosine and sine are Q1.15.
	localparam int Q_W   = 16;
	localparam int YAW_W = 16;

	// The CORDIC vector holds Q.28 values of up to about 2^33 after gain growth.
	localparam int VEC_W = 37;
	// Rotation pair in Q1.30 with headroom.
	localparam int CS_W  = 34;

	localparam logic signed [CS_W-1:0]  INV_GAIN_Q30 = CS_W'(652032874);
	localparam logic signed [VEC_W-1:0] ONE_Q28      = VEC_W'(64'sd268435456);

	localparam logic signed [YAW_W-1:0] RESET_COS = -16'sd14654;
	localparam logic signed [YAW_W-1:0] RESET_SIN = 16'sd29309;
	localparam logic signed [YAW_W-1:0] COS_UNIT  = 16'sd32767;

	localparam logic CMD_POSE  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	typedef struct packed {
		logic load;
		logic prep;
		logic sign;
		logic step;
		logic commit;
	} ppt_cmd_t;

	typedef struct packed {
		logic last_step;
		logic pipe_empty;
		logic adv;
	} ppt_stat_t;

endpackage

>>> rtl/ppt_item_if.sv
interface ppt_item_if import ppt_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic signed [CW-1:0]  pos_x;
	logic signed [CW-1:0]  pos_y;
	logic signed [CW-1:0]  pos_z;
	logic signed [Q_W-1:0] quat_x;
	logic signed [Q_W-1:0] quat_y;
	logic signed [Q_W-1:0] quat_z;
	logic signed [Q_W-1:0] quat_w;
	logic                  last_point;

	modport source (
		output valid, command, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
			last_point,
		input  ready
	);
	modport sink (
		input  valid, command, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
			last_point,
		output ready
	);
endinterface

>>> rtl/ppt_result_if.sv
interface ppt_result_if import ppt_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic signed [CW-1:0] out_z;
	logic                 out_last;

	modport source (
		output valid, out_x, out_y, out_z, out_last,
		input  ready
	);
	modport sink (
		input  valid, out_x, out_y, out_z, out_last,
		output ready
	);
endinterface

>>> rtl/ppt_ctrl.sv
module ppt_ctrl import ppt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_acc,
	input  logic      item_command,
	input  ppt_stat_t stat,
	output ppt_cmd_t  cmd,
	output logic      idle
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SIGN,
		ST_RUN,
		ST_WAIT
	} state_t;

	state_t state_q;
	logic   armed_q;

	assign idle       = (state_q == ST_IDLE);
	assign cmd.load   = idle && item_acc && (item_command == CMD_POSE) && armed_q;
	assign cmd.prep   = (state_q == ST_PREP);
	assign cmd.sign   = (state_q == ST_SIGN);
	assign cmd.step   = (state_q == ST_RUN);
	// The new pose takes effect only after every earlier point has left.
	assign cmd.commit = (state_q == ST_WAIT) && stat.pipe_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			armed_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_acc && (item_command == CMD_POINT)) begin
						armed_q <= 1'b1;
					end
					if (cmd.load) begin
						armed_q <= 1'b0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_SIGN;
				ST_SIGN: state_q <= ST_RUN;
				ST_RUN: begin
					if (stat.last_step) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (stat.pipe_empty) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_load_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !idle)
		else $error("pose load did not leave idle");

	a_commit_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !armed_q)
		else $error("point accepted while a pose was in progress");

	a_run_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && stat.last_step) |=> (state_q == ST_WAIT))
		else $error("CORDIC run did not finish after its last step");

endmodule

>>> rtl/ppt_yaw.sv
module ppt_yaw import ppt_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ppt_cmd_t                cmd,
	input  logic signed [Q_W-1:0]   quat_x,
	input  logic signed [Q_W-1:0]   quat_y,
	input  logic signed [Q_W-1:0]   quat_z,
	input  logic signed [Q_W-1:0]   quat_w,
	output logic                    last_step,
	output logic signed [YAW_W-1:0] cos_val,
	output logic signed [YAW_W-1:0] sin_val
);

	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam logic [IW-1:0] LAST_I = IW'(STEPS - 1);
	localparam int PW = 2 * Q_W;
	localparam int RW = CS_W + 1;

	logic signed [PW-1:0]    p_xy_q, p_zw_q, p_yy_q, p_zz_q;
	logic signed [VEC_W-1:0] vx_q, vy_q;
	logic signed [CS_W-1:0]  c_q, s_q;
	logic                    flip_q, zero_q;
	logic [IW-1:0]           i_q;

	logic signed [VEC_W-1:0] vx_sh, vy_sh;
	logic signed [CS_W-1:0]  c_sh, s_sh;
	logic signed [RW-1:0]    c_f, s_f;

	// Round half up from Q1.30 to Q1.15 and clamp.
	function automatic logic signed [YAW_W-1:0] to_q15(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = (v + RW'(1 << 14)) >>> 15;
		if (r > RW'(32767)) begin
			to_q15 = 16'sd32767;
		end else if (r < -RW'(32768)) begin
			to_q15 = -16'sd32768;
		end else begin
			to_q15 = r[YAW_W-1:0];
		end
	endfunction

	assign last_step = (i_q == LAST_I);

	assign vx_sh = vx_q >>> i_q;
	assign vy_sh = vy_q >>> i_q;
	assign c_sh  = c_q >>> i_q;
	assign s_sh  = s_q >>> i_q;

	assign c_f = flip_q ? -RW'(c_q) : RW'(c_q);
	assign s_f = flip_q ? -RW'(s_q) : RW'(s_q);

	assign cos_val = zero_q ? COS_UNIT : to_q15(c_f);
	assign sin_val = zero_q ? '0 : to_q15(s_f);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
		end else if (cmd.sign) begin
			i_q <= '0;
		end else if (cmd.step && !last_step) begin
			i_q <= i_q + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_xy_q <= PW'(quat_x) * PW'(quat_y);
			p_zw_q <= PW'(quat_z) * PW'(quat_w);
			p_yy_q <= PW'(quat_y) * PW'(quat_y);
			p_zz_q <= PW'(quat_z) * PW'(quat_z);
		end
		if (cmd.prep) begin
			vy_q <= (VEC_W'(p_xy_q) + VEC_W'(p_zw_q)) <<< 1;
			vx_q <= ONE_Q28 - (VEC_W'(p_yy_q) <<< 1) - (VEC_W'(p_zz_q) <<< 1);
		end
		if (cmd.sign) begin
			// A negative x component is folded by a half turn and undone at the end.
			zero_q <= (vx_q == '0) && (vy_q == '0);
			flip_q <= vx_q < 0;
			vx_q   <= (vx_q < 0) ? -vx_q : vx_q;
			vy_q   <= (vx_q < 0) ? -vy_q : vy_q;
			c_q    <= INV_GAIN_Q30;
			s_q    <= '0;
		end
		if (cmd.step) begin
			if (vy_q > 0) begin
				vx_q <= vx_q + vy_sh;
				vy_q <= vy_q - vx_sh;
				c_q  <= c_q - s_sh;
				s_q  <= s_q + c_sh;
			end else begin
				vx_q <= vx_q - vy_sh;
				vy_q <= vy_q + vx_sh;
				c_q  <= c_q + s_sh;
				s_q  <= s_q - c_sh;
			end
		end
	end

endmodule

>>> rtl/ppt_xform.sv
module ppt_xform import ppt_pkg::*; #(
	parameter int CW = COORD_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ppt_cmd_t                cmd,
	input  logic                    point_acc,
	input  logic signed [CW-1:0]    pos_x,
	input  logic signed [CW-1:0]    pos_y,
	input  logic signed [CW-1:0]    pos_z,
	input  logic                    last_point,
	input  logic signed [YAW_W-1:0] cos_val,
	input  logic signed [YAW_W-1:0] sin_val,
	input  logic                    out_ready,
	output ppt_stat_t               stat,
	output logic                    out_valid,
	output logic signed [CW-1:0]    out_x,
	output logic signed [CW-1:0]    out_y,
	output logic signed [CW-1:0]    out_z,
	output logic                    out_last
);

	localparam int PW = CW + YAW_W;
	localparam int SW = PW + 1;
	localparam int RW = CW + 2;
	localparam int TW = CW + 3;

	logic signed [CW-1:0]    off_x_q, off_y_q, pend_x_q, pend_y_q;
	logic signed [YAW_W-1:0] cos_q, sin_q;

	logic                 v1_s1, v2_s2, v3_s3;
	logic signed [PW-1:0] p_xc_s1, p_ys_s1, p_xs_s1, p_yc_s1;
	logic signed [CW-1:0] z_s1, z_s2;
	logic                 last_s1, last_s2;
	logic signed [RW-1:0] rx_s2, ry_s2;

	logic                 adv;
	logic signed [SW-1:0] sum_x, sum_y;
	logic signed [TW-1:0] tot_x, tot_y;

	function automatic logic signed [CW-1:0] sat(input logic signed [TW-1:0] v);
		logic signed [TW-1:0] hi, lo;
		hi = TW'({1'b0, {(CW-1){1'b1}}});
		lo = -hi - TW'(1);
		if (v > hi) begin
			sat = hi[CW-1:0];
		end else if (v < lo) begin
			sat = lo[CW-1:0];
		end else begin
			sat = v[CW-1:0];
		end
	endfunction

	// The whole pipe moves together whenever the output register is free.
	assign adv             = !v3_s3 || out_ready;
	assign stat.adv        = adv;
	assign stat.pipe_empty = !v1_s1 && !v2_s2 && !v3_s3;
	assign stat.last_step  = 1'b0;

	assign sum_x = SW'(p_xc_s1) - SW'(p_ys_s1) + SW'(1 << 14);
	assign sum_y = SW'(p_xs_s1) + SW'(p_yc_s1) + SW'(1 << 14);
	assign tot_x = TW'(off_x_q) + TW'(rx_s2);
	assign tot_y = TW'(off_y_q) + TW'(ry_s2);

	assign out_valid = v3_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0;
			off_y_q <= '0;
			cos_q   <= RESET_COS;
			sin_q   <= RESET_SIN;
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
		end else begin
			if (cmd.commit) begin
				off_x_q <= pend_x_q;
				off_y_q <= pend_y_q;
				cos_q   <= cos_val;
				sin_q   <= sin_val;
			end
			if (adv) begin
				v1_s1 <= point_acc;
				v2_s2 <= v1_s1;
				v3_s3 <= v2_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pend_x_q <= pos_x;
			pend_y_q <= pos_y;
		end
		if (adv) begin
			p_xc_s1  <= PW'(pos_x) * PW'(cos_q);
			p_ys_s1  <= PW'(pos_y) * PW'(sin_q);
			p_xs_s1  <= PW'(pos_x) * PW'(sin_q);
			p_yc_s1  <= PW'(pos_y) * PW'(cos_q);
			z_s1     <= pos_z;
			last_s1  <= last_point;
			rx_s2    <= sum_x[SW-1:15];
			ry_s2    <= sum_y[SW-1:15];
			z_s2     <= z_s1;
			last_s2  <= last_s1;
			out_x    <= sat(tot_x);
			out_y    <= sat(tot_y);
			out_z    <= z_s2;
			out_last <= last_s2;
		end
	end

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && adv) |=> v2_s2)
		else $error("point lost between first and second stage");

endmodule

>>> rtl/pose_point_transform_2d.sv
// Point items pass through stages s1, s2 and s3 to the result, one point per cycle while
// results are taken and no pose is in progress. An accepted pose holds off input through
// the prep and sign states, the one-step-per-cycle CORDIC run and a wait for earlier
// points to leave. A pose arriving before any point since the last pose is dropped.
// Reset (arst_n low, asynchronous) clears offsets to zero, loads the reset yaw and
// empties the point pipeline.
module pose_point_transform_2d import ppt_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ppt_item_if.sink     items,
	ppt_result_if.source results
);

	ppt_cmd_t              cmd;
	ppt_stat_t             xf_stat, ctrl_stat;
	logic                  idle, item_acc, yaw_last;
	logic signed [YAW_W-1:0] cos_val, sin_val;

	assign items.ready = idle && xf_stat.adv;
	assign item_acc    = items.valid && items.ready;

	assign ctrl_stat.adv        = xf_stat.adv;
	assign ctrl_stat.pipe_empty = xf_stat.pipe_empty;
	assign ctrl_stat.last_step  = yaw_last;

	ppt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_acc     (item_acc),
		.item_command (items.command),
		.stat         (ctrl_stat),
		.cmd          (cmd),
		.idle         (idle)
	);

	ppt_yaw #(.STEPS(CORDIC_STEPS)) u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.quat_x    (items.quat_x),
		.quat_y    (items.quat_y),
		.quat_z    (items.quat_z),
		.quat_w    (items.quat_w),
		.last_step (yaw_last),
		.cos_val   (cos_val),
		.sin_val   (sin_val)
	);

	ppt_xform #(.CW(COORD_WIDTH)) u_xform (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.point_acc  (item_acc && (items.command == CMD_POINT)),
		.pos_x      (items.pos_x),
		.pos_y      (items.pos_y),
		.pos_z      (items.pos_z),
		.last_point (items.last_point),
		.cos_val    (cos_val),
		.sin_val    (sin_val),
		.out_ready  (results.ready),
		.stat       (xf_stat),
		.out_valid  (results.valid),
		.out_x      (results.out_x),
		.out_y      (results.out_y),
		.out_z      (results.out_z),
		.out_last   (results.out_last)
	);

endmodule

>>> dv/pose_point_transform_2d_test.sv
module pose_point_transform_2d_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppt_pkg::*;

	localparam int STEPS       = CORDIC_STEPS_DEF;
	localparam int CW          = COORD_WIDTH_DEF;
	localparam int RANDOM_WORK = 1730;
	localparam int HOLD_AFTER  = 500;
	localparam int HOLD_CYCLES = 400;
	localparam int STUCK_LIMIT = 3000;

	typedef struct packed {
		logic                  command;
		logic signed [CW-1:0]  pos_x;
		logic signed [CW-1:0]  pos_y;
		logic signed [CW-1:0]  pos_z;
		logic signed [Q_W-1:0] quat_x;
		logic signed [Q_W-1:0] quat_y;
		logic signed [Q_W-1:0] quat_z;
		logic signed [Q_W-1:0] quat_w;
		logic                  last_point;
	} request_t;

	typedef struct {
		logic [CW-1:0] out_x;
		logic [CW-1:0] out_y;
		logic [CW-1:0] out_z;
		logic          out_last;
	} moved_point_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     send_valid = 1'b0;
	request_t send_req = '0;
	logic     take_ready = 1'b0;

	ppt_item_if   #(.CW(CW)) items_bus ();
	ppt_result_if #(.CW(CW)) results_bus ();

	assign items_bus.valid      = send_valid;
	assign items_bus.command    = send_req.command;
	assign items_bus.pos_x      = send_req.pos_x;
	assign items_bus.pos_y      = send_req.pos_y;
	assign items_bus.pos_z      = send_req.pos_z;
	assign items_bus.quat_x     = send_req.quat_x;
	assign items_bus.quat_y     = send_req.quat_y;
	assign items_bus.quat_z     = send_req.quat_z;
	assign items_bus.quat_w     = send_req.quat_w;
	assign items_bus.last_point = send_req.last_point;
	assign results_bus.ready    = take_ready;

	pose_point_transform_2d #(
		.CORDIC_STEPS(STEPS),
		.COORD_WIDTH (CW)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_bus),
		.results(results_bus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Pose state as the block should hold it.
	longint       offset_x = 0;
	longint       offset_y = 0;
	int           yaw_cos = RESET_COS;
	int           yaw_sin = RESET_SIN;
	bit           pose_armed = 1'b0;

	request_t     pending_items[$];
	moved_point_t expected_points[$];
	bit           gen_armed = 1'b0;
	int           queued_work = 0;

	int send_gap = 0, send_calm = 0;
	int recv_gap = 0, recv_calm = 0;
	int hold_left = 0;
	int stuck_cycles = 0;
	int points_sent = 0, poses_applied = 0, poses_dropped = 0;
	int results_checked = 0, mismatch_count = 0;

	function automatic logic [CW-1:0] clamp_coord(longint v);
		longint hi;
		hi = (longint'(1) <<< (CW - 1)) - 1;
		if (v > hi)
			return CW'(hi);
		if (v < -hi - 1)
			return CW'(-hi - 1);
		return CW'(v);
	endfunction

	function automatic int round_to_q15(longint v);
		longint r;
		r = (v + (longint'(1) <<< 14)) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return int'(r);
	endfunction

	// Yaw of the quaternion as cosine and sine. A vectoring pass on the heading
	// vector steers a rotation pass that starts from the inverse CORDIC gain.
	function automatic void update_heading(longint qx, longint qy, longint qz, longint qw);
		longint vx, vy, c, s, t;
		bit     flip;
		vy = 2 * (qx * qy + qz * qw);
		vx = (longint'(1) <<< 28) - 2 * (qy * qy + qz * qz);
		if (vx == 0 && vy == 0) begin
			yaw_cos = COS_UNIT;
			yaw_sin = 0;
			return;
		end
		flip = (vx < 0);
		if (flip) begin
			vx = -vx;
			vy = -vy;
		end
		c = longint'(INV_GAIN_Q30);
		s = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (vy > 0) begin
				t  = vx + (vy >>> i);
				vy = vy - (vx >>> i);
				vx = t;
				t  = c - (s >>> i);
				s  = s + (c >>> i);
				c  = t;
			end else begin
				t  = vx - (vy >>> i);
				vy = vy + (vx >>> i);
				vx = t;
				t  = c + (s >>> i);
				s  = s - (c >>> i);
				c  = t;
			end
		end
		if (flip) begin
			c = -c;
			s = -s;
		end
		yaw_cos = round_to_q15(c);
		yaw_sin = round_to_q15(s);
	endfunction

	function automatic void apply_request(request_t r);
		longint       px, py, rx, ry;
		moved_point_t p;
		px = longint'($signed(r.pos_x));
		py = longint'($signed(r.pos_y));
		if (r.command == CMD_POSE) begin
			if (!pose_armed) begin
				poses_dropped++;
				return;
			end
			offset_x = px;
			offset_y = py;
			update_heading(longint'($signed(r.quat_x)), longint'($signed(r.quat_y)),
				longint'($signed(r.quat_z)), longint'($signed(r.quat_w)));
			pose_armed = 1'b0;
			poses_applied++;
			return;
		end
		pose_armed = 1'b1;
		rx = (px * yaw_cos - py * yaw_sin + (longint'(1) <<< 14)) >>> 15;
		ry = (px * yaw_sin + py * yaw_cos + (longint'(1) <<< 14)) >>> 15;
		p.out_x    = clamp_coord(offset_x + rx);
		p.out_y    = clamp_coord(offset_y + ry);
		p.out_z    = r.pos_z;
		p.out_last = r.last_point;
		expected_points = {expected_points, p};
		points_sent++;
	endfunction

	function automatic void push_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [CW-1:0] z, logic last);
		request_t r;
		r.command    = CMD_POINT;
		r.pos_x      = x;
		r.pos_y      = y;
		r.pos_z      = z;
		r.quat_x     = Q_W'($urandom);
		r.quat_y     = Q_W'($urandom);
		r.quat_z     = Q_W'($urandom);
		r.quat_w     = Q_W'($urandom);
		r.last_point = last;
		pending_items = {pending_items, r};
		gen_armed = 1'b1;
		queued_work++;
	endfunction

	function automatic void push_pose(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
			logic signed [Q_W-1:0] qx, logic signed [Q_W-1:0] qy,
			logic signed [Q_W-1:0] qz, logic signed [Q_W-1:0] qw);
		request_t r;
		r.command    = CMD_POSE;
		r.pos_x      = x;
		r.pos_y      = y;
		r.pos_z      = CW'($urandom);
		r.quat_x     = qx;
		r.quat_y     = qy;
		r.quat_z     = qz;
		r.quat_w     = qw;
		r.last_point = 1'($urandom);
		pending_items = {pending_items, r};
		if (gen_armed)
			queued_work++;
		gen_armed = 1'b0;
	endfunction

	function automatic logic signed [CW-1:0] draw_coord();
		if ($urandom_range(0, 3) == 0)
			return CW'($urandom);
		return $signed(CW'($urandom)) >>> $urandom_range(4, 20);
	endfunction

	// Half near-unit quaternions about z, half raw bit patterns.
	function automatic void push_random_pose();
		real half;
		int  sgn;
		logic signed [Q_W-1:0] qx, qy, qz, qw;
		if ($urandom_range(0, 1) == 0) begin
			qx = Q_W'($urandom);
			qy = Q_W'($urandom);
			qz = Q_W'($urandom);
			qw = Q_W'($urandom);
		end else begin
			half = $urandom_range(0, 65535) * 3.14159265358979 / 65536.0;
			sgn  = ($urandom_range(0, 1) == 0) ? 1 : -1;
			qw   = Q_W'(sgn * int'($cos(half) * 16384.0));
			qz   = Q_W'(sgn * int'($sin(half) * 16384.0));
			qx   = Q_W'(int'($urandom_range(0, 400)) - 200);
			qy   = Q_W'(int'($urandom_range(0, 400)) - 200);
		end
		push_pose(draw_coord(), draw_coord(), qx, qy, qz, qw);
	endfunction

	// Gap before the next request: mostly none or short, now and then long,
	// and occasionally a calm stretch with no gaps at all.
	function automatic int draw_gap(inout int calm);
		int roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
				$signed(want), $signed(got));
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		logic nv;
		nv = send_valid;
		if (arst_n) begin
			if (send_valid && items_bus.ready) begin
				apply_request(pending_items.pop_front());
				nv = 1'b0;
				// Keep offering during the receiver hold-off so the block backs up.
				send_gap = (hold_left > 0) ? 0 : draw_gap(send_calm);
			end
			if (!nv) begin
				if (send_gap > 0)
					send_gap--;
				else if (pending_items.size() != 0) begin
					nv = 1'b1;
					send_req <= pending_items[0];
				end
			end
		end
		send_valid <= nv;
	end

	always @(posedge clk) begin
		logic         nr;
		moved_point_t want;
		nr = 1'b0;
		if (arst_n) begin
			if (results_bus.valid && take_ready) begin
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual x=%0d y=%0d",
						$time, results_bus.out_x, results_bus.out_y);
					mismatch_count++;
				end else begin
					want = expected_points.pop_front();
					check_field("out_x", want.out_x, results_bus.out_x);
					check_field("out_y", want.out_y, results_bus.out_y);
					check_field("out_z", want.out_z, results_bus.out_z);
					check_field("out_last", CW'(want.out_last), CW'(results_bus.out_last));
				end
				results_checked++;
				if (results_checked == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
				else
					recv_gap = draw_gap(recv_calm);
			end
			if (hold_left > 0)
				hold_left--;
			else if (recv_gap > 0)
				recv_gap--;
			else
				nr = 1'b1;
		end
		take_ready <= nr;
	end

	always @(posedge clk) begin
		if (!arst_n || (send_valid && items_bus.ready) || (results_bus.valid && take_ready))
			stuck_cycles <= 0;
		else if (stuck_cycles == STUCK_LIMIT) begin
			$display("%0t: no request moved for %0d cycles", $time, STUCK_LIMIT);
			$display("** pose_point_transform_2d: FAILED **");
			$finish;
		end else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int  cloud;
		bit  last;

		// Directed part. The first pose comes before any point and must be dropped.
		push_pose(123, -456, 0, 0, 0, 16384);
		push_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
		push_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1);
		push_point(65536, -65536, 0, 1'b1);
		// Identity rotation, where the cosine rounds up to one and saturates.
		push_pose(32'sh40000000, -32'sh40000000, 0, 0, 0, 16384);
		push_pose(1, 1, 5, 5, 5, 5);
		push_point(32'sh7fffffff, 32'sh7fffffff, 1234, 1'b0);
		push_point(32'sh80000000, 32'sh80000000, -1234, 1'b1);
		// Heading vector of zero length.
		push_pose(0, 0, 1000, 8192, 8192, -1000);
		push_point(32'sh00010000, 32'sh00020000, -1, 1'b1);
		// Negative x component of the heading, which turns by pi.
		push_pose(-(1 <<< 20), 1 <<< 20, 0, 0, 16384, 0);
		push_point(32'sh00030000, -32'sh00010000, 7, 1'b1);
		push_pose(32'sh7fffffff, 32'sh80000000, -32768, -32768, -32768, -32768);
		push_point(32'sh7fffffff, 0, 0, 1'b0);
		push_point(0, 32'sh7fffffff, 0, 1'b1);
		push_pose(32'sh80000000, 32'sh7fffffff, 32767, 32767, 32767, 32767);
		push_point(32'sh80000000, 32'sh80000000, 32'sh55555555, 1'b1);
		push_pose(0, 0, 32767, -32768, 32767, -32768);
		push_point(32'sh00000001, -32'sh00000001, 32'shaaaaaaaa, 1'b1);
		queued_work = 0;

		// Random clouds, each followed by a pose; some extra poses are noise.
		while (queued_work < RANDOM_WORK) begin
			if ($urandom_range(0, 9) == 0)
				push_random_pose();
			cloud = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (int k = 0; k < cloud; k++) begin
				if (k == cloud - 1)
					last = ($urandom_range(0, 9) != 0);
				else
					last = ($urandom_range(0, 19) == 0);
				push_point(draw_coord(), draw_coord(), CW'($urandom), last);
			end
			push_random_pose();
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() != 0 || send_valid)
			@(posedge clk);
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (STEPS + 12) @(posedge clk);

		$display("Sent %0d points and %0d poses (%0d poses dropped while disarmed),",
			points_sent, poses_applied, poses_dropped);
		$display("checked %0d transformed points with %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("** pose_point_transform_2d: PASSED **");
		else
			$display("** pose_point_transform_2d: FAILED **");
		$finish;
	end

endmodule
